FILE: src/tsds_pkg.sv
// ----------------------------------------------------------------------------
// tsds_pkg
// Shared types, codes and decode tables for the teleprinter shift decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsds_pkg;

  // Screen geometry.
  localparam int SCREEN_ROWS  = 16;
  localparam int SCREEN_COLS  = 40;
  localparam int SCREEN_CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int RowW  = $clog2(SCREEN_ROWS);
  localparam int ColW  = $clog2(SCREEN_COLS + 1);
  localparam int AddrW = $clog2(SCREEN_CELLS);

  // Queue between the decoder and the screen side.
  localparam int QDEPTH = 4;
  localparam int QPtrW  = $clog2(QDEPTH);
  localparam int QCntW  = $clog2(QDEPTH + 1);

  // Item kinds.
  localparam logic [1:0] KIND_CODE  = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_SHIFT = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Result events.
  localparam logic [2:0] EV_SHIFT_LET = 3'd0;
  localparam logic [2:0] EV_SHIFT_FIG = 3'd1;
  localparam logic [2:0] EV_STORED    = 3'd2;
  localparam logic [2:0] EV_DROPPED   = 3'd3;
  localparam logic [2:0] EV_NEXT_LINE = 3'd4;
  localparam logic [2:0] EV_SCROLLED  = 3'd5;
  localparam logic [2:0] EV_COL_RESET = 3'd6;
  localparam logic [2:0] EV_READ      = 3'd7;

  // Special characters.
  localparam logic [7:0] CH_SHIFT_LET = 8'd200;
  localparam logic [7:0] CH_SHIFT_FIG = 8'd201;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_NONE      = 8'd0;
  localparam logic [7:0] CODE_MAX     = 8'd31;

  localparam logic [7:0] LETTERS_TAB [32] = '{
    8'h50, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55,
    8'h49, 8'h4F, 8'h4A, 8'hC9, 8'h53, 8'h5A, 8'h4B, 8'hC8,
    8'h20, 8'h46, 8'h0D, 8'h44, 8'h20, 8'h48, 8'h4E, 8'h4D,
    8'h0A, 8'h4C, 8'h58, 8'h47, 8'h41, 8'h42, 8'h43, 8'h56
  };

  localparam logic [7:0] FIGURES_TAB [32] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h20, 8'hC9, 8'h22, 8'h2B, 8'h28, 8'hC8,
    8'h20, 8'h24, 8'h0D, 8'h3B, 8'h20, 8'h6C, 8'h2C, 8'h2E,
    8'h0A, 8'h29, 8'h2F, 8'h23, 8'h2D, 8'h3F, 8'h3A, 8'h3D
  };

  // One decoded operation for the screen side.
  typedef struct packed {
    logic [2:0]       ev;
    logic [3:0]       row;
    logic [5:0]       col;
    logic [7:0]       ch;
    logic             shift;
    logic             mem_we;
    logic             mem_re;
    logic [AddrW-1:0] addr;
  } tsds_op_t;

  // Physical row of a visible row, given the top-row pointer.
  function automatic logic [RowW-1:0] phys_row(logic [RowW-1:0] top,
                                               logic [RowW-1:0] vis);
    logic [RowW:0] sum;
    sum = {1'b0, top} + {1'b0, vis};
    if (sum >= (RowW+1)'(SCREEN_ROWS)) begin
      sum = sum - (RowW+1)'(SCREEN_ROWS);
    end
    return sum[RowW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(logic [RowW-1:0] prow,
                                                 logic [ColW-1:0] col);
    return AddrW'(prow) * AddrW'(SCREEN_COLS) + AddrW'(col);
  endfunction

endpackage

`default_nettype wire

FILE: src/tsds_front.sv
// ----------------------------------------------------------------------------
// tsds_front
// Decoder: classifies items, tracks shift, cursor and scroll, and emits ops.
// ----------------------------------------------------------------------------
`default_nettype none

module tsds_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [1:0]          kind,
  input  wire logic [7:0]          code,
  input  wire logic                shift_value,
  input  wire logic [3:0]          read_row,
  input  wire logic [5:0]          read_col,
  output tsds_pkg::tsds_op_t       op
);

  logic                          shift;
  logic                          shift_next;
  logic [tsds_pkg::RowW-1:0]     top;
  logic [tsds_pkg::RowW-1:0]     top_next;
  logic [tsds_pkg::RowW-1:0]     cursor_row;
  logic [tsds_pkg::RowW-1:0]     cursor_row_next;
  logic [tsds_pkg::ColW-1:0]     cursor_col;
  logic [tsds_pkg::ColW-1:0]     cursor_col_next;
  // Written prefix length of the cursor row; cells at or beyond it read as space.
  logic [tsds_pkg::ColW-1:0]     cur_fill;
  logic [tsds_pkg::ColW-1:0]     cur_fill_next;
  logic [tsds_pkg::ColW-1:0]     fill [tsds_pkg::SCREEN_ROWS];

  logic [7:0]                    ch_dec;
  logic [7:0]                    ch_put;
  logic [tsds_pkg::RowW-1:0]     phys_cur;
  logic [tsds_pkg::RowW-1:0]     phys_rd;
  logic                          rd_in_range;
  logic                          fill_we;
  logic                          scroll;

  assign phys_cur = tsds_pkg::phys_row(top, cursor_row);
  assign phys_rd  = tsds_pkg::phys_row(top, tsds_pkg::RowW'(read_row));
  assign rd_in_range = (int'(read_row) < tsds_pkg::SCREEN_ROWS) &&
                       (int'(read_col) < tsds_pkg::SCREEN_COLS);

  always_comb begin
    if (code > tsds_pkg::CODE_MAX) begin
      ch_dec = tsds_pkg::CH_SPACE;
    end else if (shift) begin
      ch_dec = tsds_pkg::FIGURES_TAB[code[4:0]];
    end else begin
      ch_dec = tsds_pkg::LETTERS_TAB[code[4:0]];
    end
    ch_put = (kind == tsds_pkg::KIND_RAW) ? code : ch_dec;
  end

  always_comb begin
    shift_next      = shift;
    top_next        = top;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    cur_fill_next   = cur_fill;
    fill_we         = 1'b0;
    scroll          = 1'b0;
    op.ev     = tsds_pkg::EV_READ;
    op.row    = 4'(cursor_row);
    op.col    = 6'(cursor_col);
    op.ch     = ch_put;
    op.mem_we = 1'b0;
    op.mem_re = 1'b0;
    op.addr   = tsds_pkg::cell_addr(phys_cur, cursor_col);

    case (kind)
      tsds_pkg::KIND_SHIFT: begin
        shift_next = shift_value;
        op.ev = shift_value ? tsds_pkg::EV_SHIFT_FIG : tsds_pkg::EV_SHIFT_LET;
        op.ch = tsds_pkg::CH_NONE;
      end
      tsds_pkg::KIND_READ: begin
        op.ev     = tsds_pkg::EV_READ;
        op.row    = read_row;
        op.col    = read_col;
        op.addr   = tsds_pkg::cell_addr(phys_rd, tsds_pkg::ColW'(read_col));
        if (!rd_in_range) begin
          op.ch = tsds_pkg::CH_NONE;
        end else if (tsds_pkg::ColW'(read_col) < fill[phys_rd]) begin
          op.mem_re = 1'b1;
        end else begin
          op.ch = tsds_pkg::CH_SPACE;
        end
      end
      default: begin
        if (kind == tsds_pkg::KIND_CODE && ch_dec == tsds_pkg::CH_SHIFT_LET) begin
          shift_next = 1'b0;
          op.ev = tsds_pkg::EV_SHIFT_LET;
        end else if (kind == tsds_pkg::KIND_CODE &&
                     ch_dec == tsds_pkg::CH_SHIFT_FIG) begin
          shift_next = 1'b1;
          op.ev = tsds_pkg::EV_SHIFT_FIG;
        end else if (ch_put == tsds_pkg::CH_CR) begin
          cursor_col_next = '0;
          cur_fill_next   = '0;
          if (cursor_row < tsds_pkg::RowW'(tsds_pkg::SCREEN_ROWS - 1)) begin
            cursor_row_next = cursor_row + 1'b1;
            op.ev = tsds_pkg::EV_NEXT_LINE;
          end else begin
            scroll = 1'b1;
            top_next = (top == tsds_pkg::RowW'(tsds_pkg::SCREEN_ROWS - 1)) ?
                       '0 : top + 1'b1;
            op.ev = tsds_pkg::EV_SCROLLED;
          end
          op.row = 4'(cursor_row_next);
          op.col = '0;
        end else if (ch_put == tsds_pkg::CH_LF) begin
          cursor_col_next = '0;
          op.ev  = tsds_pkg::EV_COL_RESET;
          op.col = '0;
        end else if (cursor_col < tsds_pkg::ColW'(tsds_pkg::SCREEN_COLS)) begin
          op.ev     = tsds_pkg::EV_STORED;
          op.mem_we = 1'b1;
          cursor_col_next = cursor_col + 1'b1;
          fill_we = 1'b1;
          if (cursor_col == cur_fill) begin
            cur_fill_next = cur_fill + 1'b1;
          end
        end else begin
          op.ev = tsds_pkg::EV_DROPPED;
        end
      end
    endcase
    op.shift = shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift      <= 1'b0;
      top        <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      cur_fill   <= '0;
      for (int i = 0; i < tsds_pkg::SCREEN_ROWS; i++) begin
        fill[i] <= '0;
      end
    end else if (accept) begin
      shift      <= shift_next;
      top        <= top_next;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      cur_fill   <= cur_fill_next;
      if (fill_we) begin
        fill[phys_cur] <= cur_fill_next;
      end else if (scroll) begin
        // The old top row becomes the new bottom row and reads as blank.
        fill[top] <= '0;
      end
    end
  end

  a_cursor_within_fill: assert property (@(posedge clk) disable iff (rst)
    cursor_col <= cur_fill)
    else $error("cursor column beyond written prefix of its row");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cur_fill <= tsds_pkg::ColW'(tsds_pkg::SCREEN_COLS))
    else $error("row fill count exceeds screen width");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    accept && op.ev == tsds_pkg::EV_SCROLLED && kind != tsds_pkg::KIND_READ |=>
      cursor_row == tsds_pkg::RowW'(tsds_pkg::SCREEN_ROWS - 1))
    else $error("scroll left the cursor off the bottom row");

endmodule

`default_nettype wire

FILE: src/tsds_queue.sv
// ----------------------------------------------------------------------------
// tsds_queue
// Short FIFO of decoded operations between the decoder and the screen side.
// ----------------------------------------------------------------------------
`default_nettype none

module tsds_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tsds_pkg::tsds_op_t push_op,
  output logic                    full,
  input  wire logic               pop,
  output logic                    nonempty,
  output tsds_pkg::tsds_op_t      head_op
);

  tsds_pkg::tsds_op_t          slots [tsds_pkg::QDEPTH];
  logic [tsds_pkg::QPtrW-1:0]  wr_ptr;
  logic [tsds_pkg::QPtrW-1:0]  rd_ptr;
  logic [tsds_pkg::QCntW-1:0]  count;

  assign full     = (count == tsds_pkg::QCntW'(tsds_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head_op  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tsds_pkg::QPtrW'(tsds_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tsds_pkg::QPtrW'(tsds_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tsds_pkg::QCntW'(tsds_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: src/tsds_back.sv
// ----------------------------------------------------------------------------
// tsds_back
// Screen side: performs cell writes and reads, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsds_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               op_valid,
  input  wire tsds_pkg::tsds_op_t op,
  output logic                    op_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              event_res,
  output logic [3:0]              row,
  output logic [5:0]              column,
  output logic [7:0]              char_out,
  output logic                    shift_state
);

  logic [7:0]          screen [tsds_pkg::SCREEN_CELLS];
  logic [7:0]          rd_data;
  tsds_pkg::tsds_op_t  s1;
  logic                s1_valid;
  logic                s1_adv;

  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign op_pop = op_valid && (!s1_valid || s1_adv);

  // Cell memory: one write or one read per operation, read data registered.
  always_ff @(posedge clk) begin
    if (op_pop && op.mem_we) begin
      screen[op.addr] <= op.ch;
    end
    if (op_pop && op.mem_re) begin
      rd_data <= screen[op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      s1 <= op;
    end
    if (s1_adv) begin
      event_res   <= s1.ev;
      row         <= s1.row;
      column      <= s1.col;
      char_out    <= s1.mem_re ? rd_data : s1.ch;
      shift_state <= s1.shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (op_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_mem_op: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1.mem_we && s1.mem_re))
    else $error("operation both writes and reads the screen");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced operation did not reach the result register");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    op_pop && s1_valid |-> s1_adv)
    else $error("stage overwritten while holding an operation");

endmodule

`default_nettype wire

FILE: src/teleprinter_shift_decode_screen_core.sv
// ----------------------------------------------------------------------------
// teleprinter_shift_decode_screen_core
// Letters/figures teleprinter decoder driving a scrolling character screen.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_ready    kind, code, shift_value, read_row, read_col
//  out      out_valid / out_ready  event_res, row, column, char_out,
//                                  shift_state
//
// One transaction enters per cycle and one result leaves per cycle when the
// output side keeps taking them. Each operation is registered in the queue,
// then in the screen-side stage along with the registered screen memory read,
// then in the result register. Reset clears the shift, cursor, top-row pointer
// and row fill counts; the screen memory itself is never swept.
// The decoder stalls only when its four-entry queue is full; the screen side
// stalls only when the output register is held by out_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module teleprinter_shift_decode_screen_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] code,
  input  wire logic       shift_value,
  input  wire logic [3:0] read_row,
  input  wire logic [5:0] read_col,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      event_res,
  output logic [3:0]      row,
  output logic [5:0]      column,
  output logic [7:0]      char_out,
  output logic            shift_state
);

  // The decoder (front) owns all screen bookkeeping: shift state, cursor,
  // top-row pointer and, per physical row, how many leading cells have been
  // written since the row was last blanked. Cells beyond that prefix read as
  // space, so a scroll blanks the new bottom row by zeroing its count.
  // Because writes in a row always land at the cursor, which grows from
  // column zero, the written cells of a row are always such a prefix.

  tsds_pkg::tsds_op_t front_op;
  tsds_pkg::tsds_op_t head_op;
  logic               accept;
  logic               q_full;
  logic               q_nonempty;
  logic               q_pop;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  tsds_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .code        (code),
    .shift_value (shift_value),
    .read_row    (read_row),
    .read_col    (read_col),
    .op          (front_op)
  );

  // Decoded operations wait here so the decoder keeps accepting while the
  // result register is stalled.
  tsds_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_op  (front_op),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_op  (head_op)
  );

  // The screen side applies writes and reads in queue order, so a read
  // always sees every earlier write.
  tsds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (q_nonempty),
    .op          (head_op),
    .op_pop      (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .row         (row),
    .column      (column),
    .char_out    (char_out),
    .shift_state (shift_state)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the teleprinter shift decoder and character screen.
// A short directed run covers table extremes, shifts, raw bytes, controls and
// reads. Random runs then fill lines past the right edge, scroll the screen
// many times over and read cells back. Both handshakes idle at random, and
// one stretch holds the output off until the input side stalls.
// ----------------------------------------------------------------------------

module testbench;

  import tsds_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Cycles the output side is held off in the back-pressure test.
  localparam int LONG_HOLD   = 200;

  // Decode tables, indexed by the 5-bit teleprinter code.
  localparam logic [7:0] LETTER_CHARS [32] = '{
    "P", "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "J", 8'd201, "S", "Z", "K", 8'd200,
    " ", "F", 8'd13, "D", " ", "H", "N", "M", 8'd10, "L", "X", "G", "A", "B", "C", "V"
  };
  localparam logic [7:0] FIGURE_CHARS [32] = '{
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", " ", 8'd201, "\"", "+", "(", 8'd200,
    " ", "$", 8'd13, ";", " ", "l", ",", ".", 8'd10, ")", "/", "#", "-", "?", ":", "="
  };

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic [2:0] ev;
    logic [3:0] row;
    logic [5:0] column;
    logic [7:0] ch;
    logic       shift;
  } screen_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = KIND_CODE;
  logic [7:0] code = '0;
  logic       shift_value = 1'b0;
  logic [3:0] read_row = '0;
  logic [5:0] read_col = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] event_res;
  logic [3:0] row;
  logic [5:0] column;
  logic [7:0] char_out;
  logic       shift_state;

  teleprinter_shift_decode_screen_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .code        (code),
    .shift_value (shift_value),
    .read_row    (read_row),
    .read_col    (read_col),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .row         (row),
    .column      (column),
    .char_out    (char_out),
    .shift_state (shift_state)
  );

  // The bench keeps its own copy of the screen. Cells are held by physical
  // row; the top-row pointer maps visible rows onto physical ones.
  logic [7:0] screen_cells [SCREEN_ROWS * SCREEN_COLS];
  int         top_row;
  int         cursor_row;
  int         cursor_col;
  logic       figures_on;

  screen_result_t pending_results [$];
  screen_result_t expected_result;

  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  event_count [8];
  int  hold_cycles = 0;
  int  sink_gap = 0;
  int  quiet_cycles = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Screen predictor
  // --------------------------------------------------------------------------

  function automatic int physical_row(int vis);
    return (top_row + vis) % SCREEN_ROWS;
  endfunction

  function automatic screen_result_t make_result(logic [2:0] ev, int r, int c, logic [7:0] ch);
    screen_result_t res;
    res.ev     = ev;
    res.row    = 4'(r);
    res.column = 6'(c);
    res.ch     = ch;
    res.shift  = figures_on;
    return res;
  endfunction

  // Carriage return, line feed or a printable character after decoding.
  function automatic screen_result_t place_char(logic [7:0] ch);
    int         clear_row;
    int         written_col;
    logic [2:0] ev;
    if (ch == CH_CR) begin
      if (cursor_row < SCREEN_ROWS - 1) begin
        cursor_row++;
        ev = EV_NEXT_LINE;
      end else begin
        // Scrolling rotates the top pointer; the row now at the bottom is blanked.
        top_row   = (top_row + 1) % SCREEN_ROWS;
        clear_row = physical_row(SCREEN_ROWS - 1);
        for (int c = 0; c < SCREEN_COLS; c++) begin
          screen_cells[clear_row * SCREEN_COLS + c] = CH_SPACE;
        end
        ev = EV_SCROLLED;
      end
      cursor_col = 0;
      return make_result(ev, cursor_row, cursor_col, ch);
    end
    if (ch == CH_LF) begin
      cursor_col = 0;
      return make_result(EV_COL_RESET, cursor_row, cursor_col, ch);
    end
    if (cursor_col < SCREEN_COLS) begin
      written_col = cursor_col;
      screen_cells[physical_row(cursor_row) * SCREEN_COLS + written_col] = ch;
      cursor_col++;
      return make_result(EV_STORED, cursor_row, written_col, ch);
    end
    // Line is full: the character is lost and the cursor stays put.
    return make_result(EV_DROPPED, cursor_row, cursor_col, ch);
  endfunction

  function automatic screen_result_t decode_teleprinter_item(logic [1:0] k, logic [7:0] c,
                                                             logic sv, logic [3:0] rr,
                                                             logic [5:0] rc);
    logic [7:0] ch;
    case (k)
      KIND_CODE: begin
        // Codes above the 5-bit range decode to a space.
        if (c > 8'd31) begin
          ch = CH_SPACE;
        end else begin
          ch = figures_on ? FIGURE_CHARS[c[4:0]] : LETTER_CHARS[c[4:0]];
        end
        if (ch == CH_SHIFT_LET) begin
          figures_on = 1'b0;
          return make_result(EV_SHIFT_LET, cursor_row, cursor_col, ch);
        end
        if (ch == CH_SHIFT_FIG) begin
          figures_on = 1'b1;
          return make_result(EV_SHIFT_FIG, cursor_row, cursor_col, ch);
        end
        return place_char(ch);
      end
      KIND_RAW: begin
        // Raw bytes are printed as they are, shift codes included.
        return place_char(c);
      end
      KIND_SHIFT: begin
        figures_on = sv;
        return make_result(sv ? EV_SHIFT_FIG : EV_SHIFT_LET, cursor_row, cursor_col, CH_NONE);
      end
      default: begin
        // Reads outside the screen return zero but echo the request.
        ch = CH_NONE;
        if (rr < SCREEN_ROWS && rc < SCREEN_COLS) begin
          ch = screen_cells[physical_row(rr) * SCREEN_COLS + rc];
        end
        return make_result(EV_READ, rr, rc, ch);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  function automatic int draw_gap(bit enabled);
    return enabled ? int'($urandom_range(0, 4)) : 0;
  endfunction

  // Offers one input transaction and records its expected result once the
  // block has accepted it. Valid is only lowered when an idle gap follows.
  task automatic send_item(input logic [1:0] k, input logic [7:0] c, input logic sv,
                           input logic [3:0] rr, input logic [5:0] rc);
    int gap;
    gap = draw_gap(src_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    code        <= c;
    shift_value <= sv;
    read_row    <= rr;
    read_col    <= rc;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(decode_teleprinter_item(k, c, sv, rr, rc));
    items_sent++;
  endtask

  // Fields that the kind does not use carry random values.
  task automatic send_code(input logic [7:0] c);
    send_item(KIND_CODE, c, 1'($urandom), 4'($urandom), 6'($urandom));
  endtask

  task automatic send_raw(input logic [7:0] b);
    send_item(KIND_RAW, b, 1'($urandom), 4'($urandom), 6'($urandom));
  endtask

  task automatic send_shift(input logic v);
    send_item(KIND_SHIFT, 8'($urandom), v, 4'($urandom), 6'($urandom));
  endtask

  task automatic send_read(input int r, input int c);
    send_item(KIND_READ, 8'($urandom), 1'($urandom), 4'(r), 6'(c));
  endtask

  // Any character that lands in a cell: a non-control code or a raw byte.
  task automatic send_printable();
    int c;
    if ($urandom_range(0, 1) == 1) begin
      do c = $urandom_range(0, 31); while (c == 11 || c == 15 || c == 18 || c == 24);
      send_code(8'(c));
    end else begin
      do c = $urandom_range(0, 255); while (c == CH_LF || c == CH_CR);
      send_raw(8'(c));
    end
  endtask

  task automatic send_carriage_return();
    if ($urandom_range(0, 1) == 1) begin
      send_code(8'd18);
    end else begin
      send_raw(CH_CR);
    end
  endtask

  task automatic send_random_item();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        send_code(($urandom_range(0, 7) == 0) ? 8'($urandom_range(32, 255))
                                               : 8'($urandom_range(0, 31)));
      end
      4, 5: send_raw(8'($urandom_range(0, 255)));
      6: send_shift(1'($urandom));
      default: begin
        send_read($urandom_range(0, 15),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 39));
      end
    endcase
  endtask

  task automatic pick_idle_modes();
    src_idle  = ($urandom_range(0, 3) != 0);
    sink_idle = ($urandom_range(0, 3) != 0);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Ready drops for a random number of cycles after each result, or for a
  // long stretch when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
          out_ready <= 1'b0;
        end else begin
          if (out_valid && out_ready) begin
            sink_gap = draw_gap(sink_idle);
          end
          if (sink_gap > 0) begin
            sink_gap--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      errors++;
    end
  endtask

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: event_res %0d row %0d column %0d char_out %0d",
               event_res, row, column, char_out);
        errors++;
      end else begin
        expected_result = pending_results.pop_front();
        check_field("event_res", 8'(expected_result.ev), 8'(event_res));
        check_field("row", 8'(expected_result.row), 8'(row));
        check_field("column", 8'(expected_result.column), 8'(column));
        check_field("char_out", expected_result.ch, char_out);
        check_field("shift_state", 8'(expected_result.shift), 8'(shift_state));
        event_count[expected_result.ev]++;
        results_checked++;
      end
    end
  end

  // Watchdog: the run is hung if neither side moves a transaction for long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Table extremes, every kind, both shifts and the special cases, starting
  // from the blank screen that reset leaves.
  task automatic test_directed();
    send_read(0, 0);
    send_read(15, 39);
    send_read(15, 40);               // one past the last column
    send_read(0, 63);
    send_code(8'd0);                 // first letters entry
    send_code(8'd31);                // last letters entry
    send_code(8'd255);               // beyond the 5-bit range
    send_code(8'd32);
    send_code(8'd11);                // shift to figures
    send_code(8'd5);
    send_code(8'd10);                // figures space
    send_code(8'd15);                // back to letters
    send_shift(1'b1);
    send_code(8'd21);
    send_shift(1'b0);
    send_raw(CH_SHIFT_LET);          // raw shift codes are just characters
    send_raw(CH_SHIFT_FIG);
    send_raw(8'd0);
    send_raw(8'd255);
    send_code(8'd24);                // line feed
    send_raw(CH_CR);
    send_code(8'd18);                // carriage return through the table
    send_raw(CH_LF);
    send_read(0, 0);
    send_read(0, 10);
  endtask

  // Long runs of text often overrun the right edge, so characters get dropped.
  task automatic test_full_lines();
    int n;
    for (int round = 0; round < 10; round++) begin
      pick_idle_modes();
      n = $urandom_range(36, 46);
      repeat (n) send_printable();
      repeat (3) send_read(cursor_row, $urandom_range(0, SCREEN_COLS - 1));
      if ($urandom_range(0, 2) == 0) begin
        send_code(8'd24);
        send_printable();
      end
      send_carriage_return();
    end
  endtask

  // Short lines with many returns push the cursor to the bottom and then
  // scroll the screen more than once all the way around.
  task automatic test_scrolling();
    for (int round = 0; round < 40; round++) begin
      pick_idle_modes();
      repeat ($urandom_range(0, 5)) send_printable();
      send_carriage_return();
      send_read($urandom_range(0, SCREEN_ROWS - 1), $urandom_range(0, SCREEN_COLS - 1));
      if ($urandom_range(0, 1) == 1) begin
        send_read(SCREEN_ROWS - 1, $urandom_range(0, SCREEN_COLS - 1));
      end
    end
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 300; n++) begin
      if (n % 30 == 0) begin
        pick_idle_modes();
      end
      send_random_item();
    end
  endtask

  // The output side stops long enough for the internal queue to fill, while
  // items keep arriving without gaps.
  task automatic test_back_pressure();
    src_idle    = 1'b0;
    sink_idle   = 1'b0;
    hold_cycles = LONG_HOLD;
    repeat (30) send_random_item();
    sink_idle = 1'b1;
    src_idle  = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < SCREEN_ROWS * SCREEN_COLS; i++) begin
      screen_cells[i] = CH_SPACE;
    end
    top_row    = 0;
    cursor_row = 0;
    cursor_col = 0;
    figures_on = 1'b0;
    foreach (event_count[i]) event_count[i] = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_lines();
    test_scrolling();
    test_back_pressure();
    test_random_mix();
    in_valid <= 1'b0;

    // Drain, then keep the clock running so that any stray result still shows.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d transactions and checked %0d results: %0d stored, %0d dropped,",
             items_sent, results_checked, event_count[EV_STORED], event_count[EV_DROPPED]);
    $display("%0d scrolls, %0d line moves, %0d column resets, %0d shifts, %0d cell reads.",
             event_count[EV_SCROLLED], event_count[EV_NEXT_LINE], event_count[EV_COL_RESET],
             event_count[EV_SHIFT_LET] + event_count[EV_SHIFT_FIG], event_count[EV_READ]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tsds_pkg.sv
src/tsds_front.sv
src/tsds_queue.sv
src/tsds_back.sv
src/teleprinter_shift_decode_screen_core.sv
bench/testbench.sv
